FILE: src/nnsm_pkg.sv
// Shared constants, register index codes and the configuration struct of the
// nearest-neighbor scale mapper. No dependencies; every other file uses it.

package nnsm_pkg;

    // Field widths of the configuration registers and the transactions.
    localparam int OFF_W       = 12;
    localparam int ORG_W       = 12;
    localparam int SIZE_W      = 13;
    localparam int STRIDE_W    = 14;
    localparam int CFG_DATA_W  = 14;
    localparam int CFG_INDEX_W = 3;
    localparam int OUT_COORD_W = 13;
    localparam int BYTE_W      = 27;

    // Source coordinates saturate at 2^COORD_BITS - 1 (range 8 to 16).
    localparam int COORD_BITS  = 13;

    // Derived widths.
    localparam int PROD_W = OFF_W + SIZE_W;        // offset times source size
    localparam int Q_W    = SIZE_W;                // quotient stays below the source size
    localparam int SUM_W  = SIZE_W + 1;            // origin plus scaled offset
    localparam int LIN_W  = SUM_W + STRIDE_W + 1;  // row times stride plus column
    localparam int TRI_W  = LIN_W + 2;             // times the RGB byte count

    localparam int RGB_BYTES = 3;

    // Pipeline depth: product, one stage per quotient bit, origin add, then
    // stride product, column add and the output register.
    localparam int LANE_STAGES = Q_W + 2;
    localparam int NUM_STAGES  = LANE_STAGES + 3;

    localparam logic [63:0] COORD_MAX = (64'd1 << COORD_BITS) - 64'd1;
    localparam logic [63:0] BYTE_MAX  = (64'd1 << BYTE_W) - 64'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WINDOW_LEFT,
        REG_WINDOW_TOP,
        REG_WINDOW_WIDTH,
        REG_WINDOW_HEIGHT,
        REG_TARGET_WIDTH,
        REG_TARGET_HEIGHT,
        REG_LINE_STRIDE,
        REG_GREY_MODE
    } cfg_index_t;

    typedef struct packed {
        logic [ORG_W-1:0]    window_left;
        logic [ORG_W-1:0]    window_top;
        logic [SIZE_W-1:0]   window_width;
        logic [SIZE_W-1:0]   window_height;
        logic [SIZE_W-1:0]   target_width;
        logic [SIZE_W-1:0]   target_height;
        logic [STRIDE_W-1:0] line_stride;
        logic                grey_mode;
    } cfg_t;

endpackage

FILE: src/nnsm_channels.sv
// Valid/ready channel interfaces for the request and result transactions of
// the nearest-neighbor scale mapper. Depends on nnsm_pkg.

interface nnsm_in_if;
    logic                       valid;
    logic                       ready;
    logic [nnsm_pkg::OFF_W-1:0] column_offset;
    logic [nnsm_pkg::OFF_W-1:0] row_offset;

    modport source (output valid, output column_offset, output row_offset, input ready);
    modport sink (input valid, input column_offset, input row_offset, output ready);
endinterface

interface nnsm_out_if;
    logic                             valid;
    logic                             ready;
    logic [nnsm_pkg::OUT_COORD_W-1:0] sample_column;
    logic [nnsm_pkg::OUT_COORD_W-1:0] sample_row;
    logic [nnsm_pkg::BYTE_W-1:0]      byte_offset;
    logic                             outside;

    modport source (output valid, output sample_column, output sample_row,
                    output byte_offset, output outside, input ready);
    modport sink (input valid, input sample_column, input sample_row,
                  input byte_offset, input outside, output ready);
endinterface

FILE: src/nearest_neighbor_scale_mapper.sv
// Nearest-neighbor scale mapper: top level with the stage valid chain, the
// stall control and the output register. Depends on nnsm_pkg, nnsm_channels,
// nnsm_cfg_regs, nnsm_coord_lane and nnsm_byte_offset.
//
// For each request transaction (column and row offset inside the destination
// rectangle) the block returns one result transaction naming the source pixel
// that nearest-neighbor scaling samples: sample_column = window_left +
// floor(column_offset * window_width / target_width), sample_row likewise with
// the top, heights and row offset, both saturated at 2^COORD_BITS - 1, and the
// byte offset (sample_row * line_stride + sample_column), tripled unless
// grey_mode is set and clamped to the 27-bit field. An offset at or beyond the
// target size returns outside = 1 with every other field zero. The block takes
// one transaction per clock, unless the pipeline is full and stalled, through
// NUM_STAGES = 18 register stages: one product stage, thirteen
// restoring-division stages (one quotient bit each, both axes in parallel),
// the origin add, the stride product, the column add and the output register.
// The request loads the first stage at its accepting edge and passes through
// the stages in this order until the output register presents its result.
// Every stage carries its own valid bit and advances whenever the stage after
// it is empty or advancing, so bubbles close up and requests keep being
// accepted while a finished result waits for result.ready; request.ready only
// drops when all eighteen stages hold transactions and the output is stalled.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only change while no transaction is in flight.

module nearest_neighbor_scale_mapper (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nnsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [nnsm_pkg::CFG_DATA_W-1:0]     cfg_data,
    nnsm_in_if.sink                             request,
    nnsm_out_if.source                          result
);

    localparam int NUM_STAGES  = nnsm_pkg::NUM_STAGES;
    localparam int LANE_STAGES = nnsm_pkg::LANE_STAGES;
    localparam int SUM_W       = nnsm_pkg::SUM_W;
    localparam int OUT_W       = nnsm_pkg::OUT_COORD_W;

    nnsm_pkg::cfg_t cfg;

    logic [NUM_STAGES-1:0] stage_en;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-2:0] flag_reg;
    logic [NUM_STAGES-2:0] flag_next;
    logic                  outside_in;

    logic [SUM_W-1:0] lane_column;
    logic [SUM_W-1:0] lane_row;
    logic [SUM_W-1:0] column_mid_reg;
    logic [SUM_W-1:0] row_mid_reg;
    logic [SUM_W-1:0] column_late_reg;
    logic [SUM_W-1:0] row_late_reg;
    logic [nnsm_pkg::BYTE_W-1:0] byte_late;

    logic [OUT_W-1:0]            sample_column_reg;
    logic [OUT_W-1:0]            sample_row_reg;
    logic [nnsm_pkg::BYTE_W-1:0] byte_offset_reg;
    logic                        outside_reg;

    nnsm_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // A stage may load when some stage at or after it is empty, or when the
    // output is being taken this cycle. Each enable is one masked AND-reduce.
    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_en
        localparam logic [NUM_STAGES-1:0] LOW_MASK = NUM_STAGES'((64'd1 << i) - 64'd1);
        assign stage_en[i] = result.ready || !(&(valid_reg | LOW_MASK));
    end

    assign request.ready = stage_en[0];

    // The outside decision is made on entry and travels with the transaction;
    // the arithmetic still runs on such items but its result is discarded.
    assign outside_in = (nnsm_pkg::SIZE_W'(request.column_offset) >= cfg.target_width) ||
                        (nnsm_pkg::SIZE_W'(request.row_offset) >= cfg.target_height);

    always_comb
    begin
        if (stage_en[0])
        begin
            valid_next[0] = request.valid;
            flag_next[0]  = outside_in;
        end
        else
        begin
            valid_next[0] = valid_reg[0];
            flag_next[0]  = flag_reg[0];
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (!stage_en[i])
            begin
                valid_next[i] = valid_reg[i];
            end
            else
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
        for (int i = 1; i < NUM_STAGES - 1; i++)
        begin
            if (!stage_en[i])
            begin
                flag_next[i] = flag_reg[i];
            end
            else
            begin
                flag_next[i] = flag_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flag_reg <= flag_next;
    end

    nnsm_coord_lane u_column_lane (
        .clk      (clk),
        .stage_en (stage_en[LANE_STAGES-1:0]),
        .offset   (request.column_offset),
        .origin   (cfg.window_left),
        .src_size (cfg.window_width),
        .dst_size (cfg.target_width),
        .coord    (lane_column)
    );

    nnsm_coord_lane u_row_lane (
        .clk      (clk),
        .stage_en (stage_en[LANE_STAGES-1:0]),
        .offset   (request.row_offset),
        .origin   (cfg.window_top),
        .src_size (cfg.window_height),
        .dst_size (cfg.target_height),
        .coord    (lane_row)
    );

    // Coordinates wait alongside the byte offset arithmetic.
    always_ff @(posedge clk)
    begin
        if (stage_en[LANE_STAGES])
        begin
            column_mid_reg <= lane_column;
            row_mid_reg    <= lane_row;
        end
        if (stage_en[LANE_STAGES+1])
        begin
            column_late_reg <= column_mid_reg;
            row_late_reg    <= row_mid_reg;
        end
    end

    nnsm_byte_offset u_byte_offset (
        .clk           (clk),
        .stage_en      (stage_en[LANE_STAGES+1:LANE_STAGES]),
        .sample_row    (lane_row),
        .sample_column (column_mid_reg),
        .line_stride   (cfg.line_stride),
        .grey_mode     (cfg.grey_mode),
        .byte_offset   (byte_late)
    );

    // Output register: the last pipeline stage, zeroed for outside offsets.
    always_ff @(posedge clk)
    begin
        if (stage_en[NUM_STAGES-1])
        begin
            outside_reg <= flag_reg[NUM_STAGES-2];
            if (flag_reg[NUM_STAGES-2])
            begin
                sample_column_reg <= '0;
                sample_row_reg    <= '0;
                byte_offset_reg   <= '0;
            end
            else
            begin
                sample_column_reg <= column_late_reg[OUT_W-1:0];
                sample_row_reg    <= row_late_reg[OUT_W-1:0];
                byte_offset_reg   <= byte_late;
            end
        end
    end

    assign result.valid         = valid_reg[NUM_STAGES-1];
    assign result.sample_column = sample_column_reg;
    assign result.sample_row    = sample_row_reg;
    assign result.byte_offset   = byte_offset_reg;
    assign result.outside       = outside_reg;

endmodule

FILE: src/nnsm_cfg_regs.sv
// Configuration register file of the nearest-neighbor scale mapper.
// Depends on nnsm_pkg for the register index codes and the cfg_t struct.

module nnsm_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nnsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [nnsm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output nnsm_pkg::cfg_t                      cfg
);

    nnsm_pkg::cfg_t cfg_reg;
    nnsm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (nnsm_pkg::cfg_index_t'(cfg_index))
                nnsm_pkg::REG_WINDOW_LEFT:
                    cfg_next.window_left = cfg_data[nnsm_pkg::ORG_W-1:0];
                nnsm_pkg::REG_WINDOW_TOP:
                    cfg_next.window_top = cfg_data[nnsm_pkg::ORG_W-1:0];
                nnsm_pkg::REG_WINDOW_WIDTH:
                    cfg_next.window_width = cfg_data[nnsm_pkg::SIZE_W-1:0];
                nnsm_pkg::REG_WINDOW_HEIGHT:
                    cfg_next.window_height = cfg_data[nnsm_pkg::SIZE_W-1:0];
                nnsm_pkg::REG_TARGET_WIDTH:
                    cfg_next.target_width = cfg_data[nnsm_pkg::SIZE_W-1:0];
                nnsm_pkg::REG_TARGET_HEIGHT:
                    cfg_next.target_height = cfg_data[nnsm_pkg::SIZE_W-1:0];
                nnsm_pkg::REG_LINE_STRIDE:
                    cfg_next.line_stride = cfg_data[nnsm_pkg::STRIDE_W-1:0];
                nnsm_pkg::REG_GREY_MODE:
                    cfg_next.grey_mode = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_left   <= '0;
            cfg_reg.window_top    <= '0;
            cfg_reg.window_width  <= nnsm_pkg::SIZE_W'(1);
            cfg_reg.window_height <= nnsm_pkg::SIZE_W'(1);
            cfg_reg.target_width  <= nnsm_pkg::SIZE_W'(1);
            cfg_reg.target_height <= nnsm_pkg::SIZE_W'(1);
            cfg_reg.line_stride   <= nnsm_pkg::STRIDE_W'(1);
            cfg_reg.grey_mode     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/nnsm_coord_lane.sv
// One coordinate lane: origin + floor(offset * src_size / dst_size), saturated.
// A registered product, one restoring-division stage per quotient bit and an
// origin add. Depends on nnsm_pkg.

module nnsm_coord_lane (
    input  logic                                clk,
    input  logic [nnsm_pkg::LANE_STAGES-1:0]    stage_en,
    input  logic [nnsm_pkg::OFF_W-1:0]          offset,
    input  logic [nnsm_pkg::ORG_W-1:0]          origin,
    input  logic [nnsm_pkg::SIZE_W-1:0]         src_size,
    input  logic [nnsm_pkg::SIZE_W-1:0]         dst_size,
    output logic [nnsm_pkg::SUM_W-1:0]          coord
);

    localparam int SIZE_W = nnsm_pkg::SIZE_W;
    localparam int Q_W    = nnsm_pkg::Q_W;
    localparam int PROD_W = nnsm_pkg::PROD_W;
    localparam int SUM_W  = nnsm_pkg::SUM_W;

    logic [PROD_W-1:0] prod_reg;
    logic [SIZE_W-1:0] rem_reg  [1:Q_W-1];
    logic [Q_W-1:0]    word_reg [1:Q_W];
    logic [SUM_W-1:0]  coord_reg;
    logic [SUM_W-1:0]  coord_sum;
    logic [SUM_W-1:0]  coord_next;

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            prod_reg <= PROD_W'(offset) * PROD_W'(src_size);
        end
    end

    // The quotient is known to stay below 2^Q_W when the offset is inside the
    // target, so the upper product bits seed the partial remainder directly.
    // Each stage shifts one dividend bit in and one quotient bit out.
    for (genvar k = 1; k <= Q_W; k++)
    begin : g_div
        logic [SIZE_W-1:0] rem_in;
        logic [Q_W-1:0]    word_in;
        logic [SIZE_W:0]   trial;
        logic [SIZE_W:0]   diff;
        logic              fits;

        if (k == 1)
        begin : g_first
            assign rem_in  = SIZE_W'(prod_reg[PROD_W-1:Q_W]);
            assign word_in = prod_reg[Q_W-1:0];
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign word_in = word_reg[k-1];
        end

        assign trial = {rem_in, word_in[Q_W-1]};
        assign diff  = trial - {1'b0, dst_size};
        assign fits  = (trial >= {1'b0, dst_size});

        always_ff @(posedge clk)
        begin
            if (stage_en[k])
            begin
                word_reg[k] <= {word_in[Q_W-2:0], fits};
            end
        end

        if (k < Q_W)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (stage_en[k])
                begin
                    rem_reg[k] <= fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
                end
            end
        end
    end

    assign coord_sum = SUM_W'(origin) + SUM_W'(word_reg[Q_W]);

    always_comb
    begin
        if (64'(coord_sum) > nnsm_pkg::COORD_MAX)
        begin
            coord_next = SUM_W'(nnsm_pkg::COORD_MAX);
        end
        else
        begin
            coord_next = coord_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[Q_W+1])
        begin
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

FILE: src/nnsm_byte_offset.sv
// Byte offset of the sampled pixel: row * stride + column, times three for
// RGB, saturated to the offset field. Two register stages and a final
// combinational scale and clamp. Depends on nnsm_pkg.

module nnsm_byte_offset (
    input  logic                                clk,
    input  logic [1:0]                          stage_en,
    input  logic [nnsm_pkg::SUM_W-1:0]          sample_row,
    input  logic [nnsm_pkg::SUM_W-1:0]          sample_column,
    input  logic [nnsm_pkg::STRIDE_W-1:0]       line_stride,
    input  logic                                grey_mode,
    output logic [nnsm_pkg::BYTE_W-1:0]         byte_offset
);

    localparam int LIN_W = nnsm_pkg::LIN_W;
    localparam int TRI_W = nnsm_pkg::TRI_W;

    logic [LIN_W-1:0] prod_reg;
    logic [LIN_W-1:0] lin_reg;
    logic [TRI_W-1:0] scaled;

    // The row arrives one stage ahead of the column it is added to.
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            prod_reg <= LIN_W'(sample_row) * LIN_W'(line_stride);
        end
        if (stage_en[1])
        begin
            lin_reg <= prod_reg + LIN_W'(sample_column);
        end
    end

    always_comb
    begin
        if (grey_mode)
        begin
            scaled = TRI_W'(lin_reg);
        end
        else
        begin
            scaled = TRI_W'(lin_reg) * TRI_W'(nnsm_pkg::RGB_BYTES);
        end

        if (64'(scaled) > nnsm_pkg::BYTE_MAX)
        begin
            byte_offset = nnsm_pkg::BYTE_MAX[nnsm_pkg::BYTE_W-1:0];
        end
        else
        begin
            byte_offset = scaled[nnsm_pkg::BYTE_W-1:0];
        end
    end

endmodule

FILE: src/nnsm_checker.sv
// Port-level assertions for the nearest-neighbor scale mapper and the bind
// that attaches them to the top level. Depends on nnsm_pkg.

module nnsm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_ready,
    input logic                             res_valid,
    input logic                             res_ready,
    input logic [nnsm_pkg::OUT_COORD_W-1:0] sample_column,
    input logic [nnsm_pkg::OUT_COORD_W-1:0] sample_row,
    input logic [nnsm_pkg::BYTE_W-1:0]      byte_offset,
    input logic                             outside
);

    // A stalled result transaction keeps its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(sample_column) &&
        $stable(sample_row) && $stable(byte_offset) && $stable(outside))
        else $error("result transaction changed while stalled");

    // An outside result carries no coordinates and no offset.
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && outside |-> sample_column == '0 && sample_row == '0 &&
        byte_offset == '0)
        else $error("outside result with nonzero fields");

    // With the output stage empty there is room somewhere in the pipeline.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> req_ready)
        else $error("request refused while the output stage is empty");

    // The pipeline comes out of reset empty, so no result is offered in the
    // first cycle after reset is released.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid directly after reset");

endmodule

bind nearest_neighbor_scale_mapper nnsm_checker u_nnsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_ready     (request.ready),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .sample_column (result.sample_column),
    .sample_row    (result.sample_row),
    .byte_offset   (result.byte_offset),
    .outside       (result.outside)
);

FILE: tb/tb_nearest_neighbor_scale_mapper.sv
`timescale 1ns / 1ps
// Self-checking testbench for nearest_neighbor_scale_mapper: a scoreboard class
// predicts each sampled source pixel, tasks send requests, a loop takes results.
// Depends on nnsm_pkg, nnsm_channels and the block under test.

// One result transaction as the block reports it.
typedef struct packed {
    logic [nnsm_pkg::OUT_COORD_W-1:0] column;
    logic [nnsm_pkg::OUT_COORD_W-1:0] row;
    logic [nnsm_pkg::BYTE_W-1:0]      byte_offset;
    logic                             outside;
} sample_t;

// Holds a private copy of the register file, predicts the sampled source pixel
// of every accepted request and compares each result with the oldest prediction.
class sample_tracker;
    nnsm_pkg::cfg_t regs;
    sample_t        pending_samples[$];
    int unsigned    mismatches;

    function new();
        regs               = '0;
        regs.window_width  = 13'd1;
        regs.window_height = 13'd1;
        regs.target_width  = 13'd1;
        regs.target_height = 13'd1;
        regs.line_stride   = 14'd1;
        mismatches         = 0;
    endfunction

    function void write_register(nnsm_pkg::cfg_index_t idx,
                                 logic [nnsm_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            nnsm_pkg::REG_WINDOW_LEFT:   regs.window_left   = value[nnsm_pkg::ORG_W-1:0];
            nnsm_pkg::REG_WINDOW_TOP:    regs.window_top    = value[nnsm_pkg::ORG_W-1:0];
            nnsm_pkg::REG_WINDOW_WIDTH:  regs.window_width  = value[nnsm_pkg::SIZE_W-1:0];
            nnsm_pkg::REG_WINDOW_HEIGHT: regs.window_height = value[nnsm_pkg::SIZE_W-1:0];
            nnsm_pkg::REG_TARGET_WIDTH:  regs.target_width  = value[nnsm_pkg::SIZE_W-1:0];
            nnsm_pkg::REG_TARGET_HEIGHT: regs.target_height = value[nnsm_pkg::SIZE_W-1:0];
            nnsm_pkg::REG_LINE_STRIDE:   regs.line_stride   = value[nnsm_pkg::STRIDE_W-1:0];
            nnsm_pkg::REG_GREY_MODE:     regs.grey_mode     = value[0];
            default: ;
        endcase
    endfunction

    // Nearest-neighbor mapping with exact integer floors. A zero target size
    // can never be reached by the scaling path, since every offset is then
    // at or beyond it.
    function sample_t map_to_source(logic [nnsm_pkg::OFF_W-1:0] col,
                                    logic [nnsm_pkg::OFF_W-1:0] row);
        sample_t         s;
        longint unsigned col64, row64, scol, srow, lin;
        s     = '0;
        col64 = 64'(col);
        row64 = 64'(row);
        if (col64 >= 64'(regs.target_width) || row64 >= 64'(regs.target_height))
        begin
            s.outside = 1'b1;
            return s;
        end
        scol = 64'(regs.window_left);
        scol = scol + col64 * 64'(regs.window_width) / 64'(regs.target_width);
        srow = 64'(regs.window_top);
        srow = srow + row64 * 64'(regs.window_height) / 64'(regs.target_height);
        if (scol > nnsm_pkg::COORD_MAX)
            scol = nnsm_pkg::COORD_MAX;
        if (srow > nnsm_pkg::COORD_MAX)
            srow = nnsm_pkg::COORD_MAX;
        lin = srow * 64'(regs.line_stride) + scol;
        if (!regs.grey_mode)
            lin = lin * 64'(nnsm_pkg::RGB_BYTES);
        if (lin > nnsm_pkg::BYTE_MAX)
            lin = nnsm_pkg::BYTE_MAX;
        s.column      = scol[nnsm_pkg::OUT_COORD_W-1:0];
        s.row         = srow[nnsm_pkg::OUT_COORD_W-1:0];
        s.byte_offset = lin[nnsm_pkg::BYTE_W-1:0];
        return s;
    endfunction

    function void note_request(logic [nnsm_pkg::OFF_W-1:0] col,
                               logic [nnsm_pkg::OFF_W-1:0] row);
        pending_samples.push_back(map_to_source(col, row));
    endfunction

    function void check_result(sample_t got);
        sample_t want;
        if (pending_samples.size() == 0)
        begin
            $display("%0t: result with nothing pending: col %0d row %0d bytes %0d outside %0b",
                     $time, got.column, got.row, got.byte_offset, got.outside);
            mismatches++;
            return;
        end
        want = pending_samples.pop_front();
        if (got.column !== want.column || got.row !== want.row
            || got.byte_offset !== want.byte_offset || got.outside !== want.outside)
        begin
            $display("%0t: mismatch: expected col %0d row %0d bytes %0d outside %0b",
                     $time, want.column, want.row, want.byte_offset, want.outside);
            $display("%0t:           actual   col %0d row %0d bytes %0d outside %0b",
                     $time, got.column, got.row, got.byte_offset, got.outside);
            mismatches++;
        end
    endfunction
endclass

module tb_nearest_neighbor_scale_mapper;

    // Cycles without any accepted transaction before the run is declared hung.
    // The longest legitimate quiet stretch is the pipeline latency after a
    // drain or a register update plus a run of idle receiver cycles, far
    // below this.
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [nnsm_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [nnsm_pkg::CFG_DATA_W-1:0]  cfg_data;

    // When set, neither side idles: the sender presents back to back and the
    // receiver holds ready high.
    bit steady = 1'b0;

    int unsigned stall_cycles = 0;

    sample_tracker tracker = new();

    nnsm_in_if  request_ch ();
    nnsm_out_if result_ch ();

    nearest_neighbor_scale_mapper uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request_ch),
        .result    (result_ch)
    );

    always #2 clk = ~clk;

    // Present one request and hold it until the block takes it. Idle cycles
    // are inserted before the request, so gaps land at random pipeline phases.
    // valid is only ever assigned once per time step: either the gap lowers it
    // or the new request keeps it high.
    task automatic send_request(input logic [nnsm_pkg::OFF_W-1:0] col,
                                input logic [nnsm_pkg::OFF_W-1:0] row);
        while (!steady && $urandom_range(99) < 36)
        begin
            request_ch.valid <= 1'b0;
            @(posedge clk);
        end
        request_ch.valid         <= 1'b1;
        request_ch.column_offset <= col;
        request_ch.row_offset    <= row;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
        tracker.note_request(col, row);
    endtask

    // Stop sending and wait until every predicted sample has come back, which
    // leaves the whole pipeline empty.
    task automatic drain_results();
        request_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_samples.size() != 0)
            @(posedge clk);
    endtask

    // Write all eight registers, one per clock, walking the index enum. The
    // block must be idle when this is called.
    task automatic program_registers(input nnsm_pkg::cfg_t setting);
        nnsm_pkg::cfg_index_t            idx;
        logic [nnsm_pkg::CFG_DATA_W-1:0] value;
        idx = idx.first();
        repeat (idx.num())
        begin
            case (idx)
                nnsm_pkg::REG_WINDOW_LEFT:
                    value = nnsm_pkg::CFG_DATA_W'(setting.window_left);
                nnsm_pkg::REG_WINDOW_TOP:
                    value = nnsm_pkg::CFG_DATA_W'(setting.window_top);
                nnsm_pkg::REG_WINDOW_WIDTH:
                    value = nnsm_pkg::CFG_DATA_W'(setting.window_width);
                nnsm_pkg::REG_WINDOW_HEIGHT:
                    value = nnsm_pkg::CFG_DATA_W'(setting.window_height);
                nnsm_pkg::REG_TARGET_WIDTH:
                    value = nnsm_pkg::CFG_DATA_W'(setting.target_width);
                nnsm_pkg::REG_TARGET_HEIGHT:
                    value = nnsm_pkg::CFG_DATA_W'(setting.target_height);
                nnsm_pkg::REG_LINE_STRIDE:
                    value = nnsm_pkg::CFG_DATA_W'(setting.line_stride);
                nnsm_pkg::REG_GREY_MODE:
                    value = nnsm_pkg::CFG_DATA_W'(setting.grey_mode);
                default:
                    value = '0;
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(posedge clk);
            tracker.write_register(idx, value);
            idx = idx.next();
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Rectangle sizes lean toward the edges: zero, one, the field maximum and
    // small sizes show up far more often than a uniform draw would give.
    function automatic logic [nnsm_pkg::SIZE_W-1:0] pick_extent();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 13'd1;
            2:       return '1;
            3, 4, 5: return nnsm_pkg::SIZE_W'($urandom_range(16, 1));
            default: return nnsm_pkg::SIZE_W'($urandom_range(4096, 1));
        endcase
    endfunction

    function automatic nnsm_pkg::cfg_t random_setting();
        nnsm_pkg::cfg_t s;
        case ($urandom_range(3))
            0:       s.window_left = '0;
            1:       s.window_left = '1;
            default: s.window_left = nnsm_pkg::ORG_W'($urandom_range(4095));
        endcase
        case ($urandom_range(3))
            0:       s.window_top = '0;
            1:       s.window_top = '1;
            default: s.window_top = nnsm_pkg::ORG_W'($urandom_range(4095));
        endcase
        s.window_width  = pick_extent();
        s.window_height = pick_extent();
        s.target_width  = pick_extent();
        s.target_height = pick_extent();
        case ($urandom_range(5))
            0:       s.line_stride = '0;
            1:       s.line_stride = 14'd1;
            2:       s.line_stride = '1;
            3:       s.line_stride = nnsm_pkg::STRIDE_W'($urandom_range(64, 1));
            default: s.line_stride = nnsm_pkg::STRIDE_W'($urandom_range(16383));
        endcase
        s.grey_mode = 1'($urandom_range(1));
        return s;
    endfunction

    // Most offsets fall inside the destination rectangle so the scaling path
    // gets real work; the rest span the whole field and are mostly outside.
    function automatic logic [nnsm_pkg::OFF_W-1:0] pick_offset(
        logic [nnsm_pkg::SIZE_W-1:0] span);
        if (span != 0 && $urandom_range(9) < 8)
            return nnsm_pkg::OFF_W'($urandom_range((span > 4096 ? 4096 : span) - 1));
        return nnsm_pkg::OFF_W'($urandom_range(4095));
    endfunction

    task automatic run_random_phase(input int unsigned count);
        program_registers(random_setting());
        repeat (count)
        begin
            send_request(pick_offset(tracker.regs.target_width),
                         pick_offset(tracker.regs.target_height));
            // Now and then the sender holds off until the pipeline is empty.
            if ($urandom_range(99) == 0)
                drain_results();
        end
        drain_results();
    endtask

    // Result side: check every accepted transaction, then decide ready for
    // the next cycle. Sampling happens at the edge, before any update.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                tracker.check_result('{result_ch.sample_column, result_ch.sample_row,
                                       result_ch.byte_offset, result_ch.outside});
            result_ch.ready <= rst_n && (steady || $urandom_range(99) >= 36);
        end
    end

    // Watchdog: any accepted transaction on either channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (request_ch.valid && request_ch.ready)
            || (result_ch.valid && result_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("nearest_neighbor_scale_mapper regression: fail");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        nnsm_pkg::cfg_t setting;
        rst_n                    <= 1'b0;
        cfg_we                   <= 1'b0;
        cfg_index                <= nnsm_pkg::REG_WINDOW_LEFT;
        cfg_data                 <= '0;
        request_ch.valid         <= 1'b0;
        request_ch.column_offset <= '0;
        request_ch.row_offset    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: a 1x1 destination, so only the origin is inside.
        send_request(12'd0, 12'd0);
        send_request(12'd1, 12'd0);
        send_request(12'd0, 12'd1);
        send_request(12'hFFF, 12'hFFF);
        drain_results();

        // Largest window and stride at the far corner: both coordinates
        // saturate and the RGB byte offset clamps.
        setting.window_left   = '1;
        setting.window_top    = '1;
        setting.window_width  = '1;
        setting.window_height = '1;
        setting.target_width  = 13'd4096;
        setting.target_height = 13'd4096;
        setting.line_stride   = '1;
        setting.grey_mode     = 1'b0;
        program_registers(setting);
        send_request(12'd0, 12'd0);
        send_request(12'hFFF, 12'hFFF);
        send_request(12'hFFF, 12'd0);
        send_request(12'd0, 12'hFFF);
        send_request(12'd2048, 12'd2048);
        drain_results();

        // Zero window size collapses every offset onto the window corner;
        // zero stride and greyscale keep the byte offset at the column.
        setting.window_left   = '0;
        setting.window_top    = '0;
        setting.window_width  = '0;
        setting.window_height = '0;
        setting.target_width  = '1;
        setting.target_height = '1;
        setting.line_stride   = '0;
        setting.grey_mode     = 1'b1;
        program_registers(setting);
        send_request(12'hFFF, 12'hFFF);
        send_request(12'd0, 12'd0);
        send_request(12'd1234, 12'd3000);
        drain_results();

        // Zero target width: every offset is outside.
        setting.window_left   = 12'd10;
        setting.window_top    = 12'd20;
        setting.window_width  = 13'd100;
        setting.window_height = 13'd100;
        setting.target_width  = '0;
        setting.target_height = 13'd5;
        setting.line_stride   = 14'd640;
        setting.grey_mode     = 1'b0;
        program_registers(setting);
        send_request(12'd0, 12'd0);
        send_request(12'd0, 12'd4);
        send_request(12'hFFF, 12'd0);
        drain_results();

        // Ordinary 2:1 downscale, probing both edges of the destination.
        setting.window_left   = 12'd7;
        setting.window_top    = 12'd9;
        setting.window_width  = 13'd640;
        setting.window_height = 13'd480;
        setting.target_width  = 13'd320;
        setting.target_height = 13'd240;
        setting.line_stride   = 14'd1024;
        program_registers(setting);
        send_request(12'd0, 12'd0);
        send_request(12'd319, 12'd239);
        send_request(12'd320, 12'd0);
        send_request(12'd0, 12'd240);
        send_request(12'd160, 12'd120);
        send_request(12'hAAA, 12'h555);
        send_request(12'h555, 12'hAAA);
        drain_results();

        // Random register settings, each with a burst of random offsets.
        // One phase runs with no idling on either side.
        for (int phase = 0; phase < 12; phase++)
        begin
            steady = (phase == 5);
            run_random_phase(78);
        end
        steady = 1'b0;

        drain_results();
        repeat (nnsm_pkg::NUM_STAGES + 4) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("nearest_neighbor_scale_mapper regression: pass");
        else
            $display("nearest_neighbor_scale_mapper regression: fail");
        $finish;
    end

endmodule
